// ----- rtl/atk_pkg.sv -----
// Shared types, constants and arithmetic helpers for the Atkinson dither unit.
// No dependencies; imported by every module of the block except atk_ram.
package atk_pkg;

  localparam int CFG_W       = 9;
  localparam int SHARE_DIV   = 8;
  localparam int SHARE_SHIFT = $clog2(SHARE_DIV);

  localparam logic [7:0] LEVEL_MAX = 8'd255;
  localparam logic [7:0] LEVEL_MID = 8'd127;
  localparam logic [1:0] ROWS_FULL = 2'd2;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 9'd160;

  typedef logic signed [4:0] share_t;

  typedef struct packed {
    logic last;
    logic has_left;
    logic use_up;
    logic use_up2;
  } pix_flags_t;

  typedef struct packed {
    share_t up2;
    share_t up_left;
    share_t up;
    share_t up_right;
    share_t back_two;
    share_t back_one;
  } shares_t;

  function automatic logic [7:0] add_clamp(input logic [7:0] level, input share_t share);
    logic [9:0] t;
    t = {2'b00, level} + {{5{share[4]}}, share};
    if (t[9]) begin
      return 8'd0;
    end else if (t[8]) begin
      return LEVEL_MAX;
    end
    return t[7:0];
  endfunction

  function automatic share_t share_of(input logic [7:0] level);
    logic [7:0] m;
    logic [4:0] q;
    if (level > LEVEL_MID) begin
      m = LEVEL_MAX - level;
      q = 5'(m >> SHARE_SHIFT);
      return share_t'(5'd0 - q);
    end
    return share_t'(5'(level >> SHARE_SHIFT));
  endfunction

endpackage

// ----- rtl/atk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atk_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/atk_pos.sv -----
// Raster position tracking: column and rows seen, row wrap, frame restart.
// Depends on atk_pkg.
module atk_pos
  import atk_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         frame_start,
  input  logic [CFG_W-1:0]             image_width,
  output logic [$clog2(MAX_WIDTH)-1:0] x,
  output pix_flags_t                   flags
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  logic [AW-1:0] column;
  logic [1:0]    rows_seen;
  logic [LW-1:0] iw_ext;
  logic [LW-1:0] w_eff;
  logic          wrap;
  logic [1:0]    rows_cur;
  logic [1:0]    rows_inc;
  logic [1:0]    rows_end;

  assign iw_ext = LW'(image_width);
  assign w_eff  = (iw_ext == '0) ? LW'(1) :
                  (iw_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : iw_ext;
  assign wrap   = !frame_start && (LW'(column) >= w_eff);

  assign rows_inc = (rows_seen >= ROWS_FULL) ? rows_seen : rows_seen + 2'd1;
  assign rows_cur = frame_start ? 2'd0 : (wrap ? rows_inc : rows_seen);
  assign rows_end = (rows_cur >= ROWS_FULL) ? rows_cur : rows_cur + 2'd1;

  assign x = (frame_start || wrap) ? '0 : column;

  assign flags.last     = (LW'(x) + LW'(1)) == w_eff;
  assign flags.has_left = (x != '0);
  assign flags.use_up   = (rows_cur != 2'd0);
  assign flags.use_up2  = (rows_cur >= ROWS_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      rows_seen <= '0;
    end else if (accept) begin
      column    <= flags.last ? '0 : x + AW'(1);
      rows_seen <= flags.last ? rows_end : rows_cur;
    end
  end

  a_rows_sat: assert property (@(posedge clk) disable iff (rst) rows_seen <= ROWS_FULL)
    else $error("rows_seen passed saturation");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    column <= AW'(MAX_WIDTH - 1))
    else $error("column beyond line buffer depth");

endmodule

// ----- rtl/atk_level.sv -----
// Pixel adjust and quantize: six clamped share adds, threshold, error share.
// Depends on atk_pkg.
module atk_level
  import atk_pkg::*;
(
  input  logic [7:0] gray,
  input  pix_flags_t flags,
  input  shares_t    shares,
  output logic       out_bit,
  output share_t     share
);

  logic [7:0] l0, l1, l2, l3, l4, l5, l6;

  always_comb begin
    l0 = gray;
    l1 = add_clamp(l0, flags.use_up2 ? shares.up2 : share_t'(0));
    l2 = add_clamp(l1, (flags.use_up && flags.has_left) ? shares.up_left : share_t'(0));
    l3 = add_clamp(l2, flags.use_up ? shares.up : share_t'(0));
    l4 = add_clamp(l3, (flags.use_up && !flags.last) ? shares.up_right : share_t'(0));
    l5 = add_clamp(l4, flags.has_left ? shares.back_two : share_t'(0));
    l6 = add_clamp(l5, flags.has_left ? shares.back_one : share_t'(0));
  end

  assign out_bit = (l6 > LEVEL_MID);
  assign share   = share_of(l6);

endmodule

// ----- rtl/atkinson_error_diffusion_1bit_unit.sv -----
// Atkinson error diffusion of 8-bit gray pixels to one bit per pixel.
// Depends on atk_pkg, atk_pos, atk_level and atk_ram.
//
// Pixels enter on s_axis in raster order, one per transfer; tuser marks the
// first pixel of a frame. Each pixel gives one transfer on m_axis: the
// dithered bit in tdata bit 0 and tlast on the last pixel of a row.
// image_width is to be written on the cfg channel between frames, while idle; the block does not enforce it.
//
// Each pixel is registered in the input stage and then in the output
// register before it shows on m_axis. Throughput is one pixel per clock
// while m_axis does not stall: in the input stage the six clamped
// share adds run against the line buffer read data, and each line buffer
// port serves one read and one write per pixel.
//
// Reset clears the position, the row shares and the width (to 160); the
// line buffers are not cleared and hold no meaning until the rows above
// have been written in the current frame. When m_axis stalls, the output
// register holds, the input stage holds behind it and s_axis_tready drops.
module atkinson_error_diffusion_1bit_unit
  import atk_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,      // image_width
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] gray_pixel
  input  logic             s_axis_tuser,  // [0] frame_start
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [0] out_bit, [7:1] zero
  output logic             m_axis_tlast   // row_end
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0] image_width;

  logic          accept;
  logic          adv;
  logic [AW-1:0] pos_x;
  logic [AW-1:0] pos_x1;
  pix_flags_t    pos_flags;

  logic          s1_valid;
  logic [7:0]    s1_gray;
  logic [AW-1:0] s1_x;
  pix_flags_t    s1_flags;

  logic [4:0] qa, qb0, qb1;
  logic       fa_v, fb0_v, fb1_v;
  share_t     fa_d, fb0_d, fb1_d;
  share_t     a_eff, b0_eff, b1_eff;

  share_t  sb1, sb2, up_prev;
  shares_t shares;
  logic    bit_c;
  share_t  share_c;

  logic          pend_v;
  logic [AW-1:0] pend_addr;
  share_t        pend_data;
  logic          new_pend;

  logic          b_from_item;
  logic          wb_en;
  logic [AW-1:0] wb_addr;
  share_t        wb_data;

  logic m_valid;
  logic m_bit;
  logic m_last;

  assign cfg_ready = 1'b1;

  assign adv           = s1_valid && (!m_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  atk_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (s_axis_tuser),
    .image_width (image_width),
    .x           (pos_x),
    .flags       (pos_flags)
  );

  assign pos_x1 = pos_x + AW'(1);

  assign a_eff  = fa_v  ? fa_d  : share_t'(qa);
  assign b0_eff = fb0_v ? fb0_d : share_t'(qb0);
  assign b1_eff = fb1_v ? fb1_d : share_t'(qb1);

  assign shares.up2      = a_eff;
  assign shares.up_left  = up_prev;
  assign shares.up       = b0_eff;
  assign shares.up_right = b1_eff;
  assign shares.back_two = sb2;
  assign shares.back_one = sb1;

  atk_level u_level (
    .gray    (s1_gray),
    .flags   (s1_flags),
    .shares  (shares),
    .out_bit (bit_c),
    .share   (share_c)
  );

  // Row above moves to two-up; current row lands one behind the pixel.
  assign new_pend    = adv && s1_flags.last;
  assign b_from_item = adv && s1_flags.has_left;
  assign wb_en       = b_from_item || pend_v;
  assign wb_addr     = b_from_item ? s1_x - AW'(1) : pend_addr;
  assign wb_data     = b_from_item ? sb1 : pend_data;

  atk_ram #(.WIDTH(5), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_x),
    .wdata (b0_eff),
    .re    (accept),
    .raddr (pos_x),
    .rdata (qa)
  );

  atk_ram #(.WIDTH(5), .DEPTH(MAX_WIDTH)) u_line_b0 (
    .clk   (clk),
    .we    (wb_en),
    .waddr (wb_addr),
    .wdata (wb_data),
    .re    (accept),
    .raddr (pos_x),
    .rdata (qb0)
  );

  atk_ram #(.WIDTH(5), .DEPTH(MAX_WIDTH)) u_line_b1 (
    .clk   (clk),
    .we    (wb_en),
    .waddr (wb_addr),
    .wdata (wb_data),
    .re    (accept),
    .raddr (pos_x1),
    .rdata (qb1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      s1_valid    <= 1'b0;
      m_valid     <= 1'b0;
      pend_v      <= 1'b0;
      sb1         <= '0;
      sb2         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        image_width <= cfg_data;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      pend_v <= new_pend;
      if (adv) begin
        sb2 <= s1_flags.has_left ? sb1 : share_t'(0);
        sb1 <= share_c;
      end
    end
  end

  // Forward same-edge writes into the read ports: reads return old data.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gray  <= s_axis_tdata;
      s1_x     <= pos_x;
      s1_flags <= pos_flags;
      fa_v     <= adv && (s1_x == pos_x);
      fa_d     <= b0_eff;
      if (new_pend && (s1_x == pos_x)) begin
        fb0_v <= 1'b1;
        fb0_d <= share_c;
      end else begin
        fb0_v <= wb_en && (wb_addr == pos_x);
        fb0_d <= wb_data;
      end
      if (new_pend && (s1_x == pos_x1)) begin
        fb1_v <= 1'b1;
        fb1_d <= share_c;
      end else begin
        fb1_v <= wb_en && (wb_addr == pos_x1);
        fb1_d <= wb_data;
      end
    end
    if (adv) begin
      up_prev <= b0_eff;
      m_bit   <= bit_c;
      m_last  <= s1_flags.last;
    end
    if (new_pend) begin
      pend_addr <= s1_x;
      pend_data <= share_c;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'd0, m_bit};
  assign m_axis_tlast  = m_last;

  a_pend_port: assert property (@(posedge clk) disable iff (rst)
    pend_v && adv |-> s1_x == '0)
    else $error("pending row-end share collides with a line write");
  a_pend_set: assert property (@(posedge clk) disable iff (rst)
    adv && s1_flags.last |=> pend_v)
    else $error("row-end share not queued");
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_x) && $stable(s1_gray))
    else $error("input stage lost a stalled pixel");

endmodule

// ----- dv/tb_atkinson_error_diffusion_1bit_unit.sv -----
// Self-checking testbench for atkinson_error_diffusion_1bit_unit: streams gray
// frames at several row widths and checks each dithered bit against a local
// Atkinson predictor. Depends on atk_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_atkinson_error_diffusion_1bit_unit;
  import atk_pkg::*;

  localparam int MAX_W = 256;

  typedef struct packed {
    logic out_bit;
    logic row_end;
  } dither_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;  // [7:0] gray_pixel
  logic             s_axis_tuser = 1'b0; // [0] frame_start
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;       // [0] out_bit, [7:1] zero
  logic             m_axis_tlast;       // row_end

  atkinson_error_diffusion_1bit_unit #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // dither predictor state
  logic [CFG_W-1:0] width_reg = WIDTH_RESET;
  share_t           shares_up2[MAX_W];
  share_t           shares_up[MAX_W];
  int               next_col = 0;
  int               rows_done = 0;
  share_t           left_share = '0;
  share_t           left2_share = '0;
  dither_result_t   dither_q[$];

  int   n_errors = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic rx_hold_go = 1'b0;
  logic rx_hold_seen = 1'b0;
  int   rx_hold_left = 0;

  function automatic int sat_add(input int lvl, input share_t s);
    int t;
    t = lvl + int'(s);
    if (t < 0) return 0;
    if (t > int'(LEVEL_MAX)) return int'(LEVEL_MAX);
    return t;
  endfunction

  function automatic void start_new_row();
    next_col = 0;
    left_share = '0;
    left2_share = '0;
  endfunction

  function automatic void predict_pixel(input logic [7:0] gray, input logic frame_start);
    int w;
    int x;
    int lvl;
    int err;
    dither_result_t r;
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (frame_start) begin
      rows_done = 0;
      start_new_row();
    end else if (next_col >= w) begin
      if (rows_done < 2) rows_done++;
      start_new_row();
    end
    x = next_col;
    r.row_end = (x + 1 == w);
    lvl = int'(gray);
    if (rows_done >= 2) lvl = sat_add(lvl, shares_up2[x]);
    if (rows_done >= 1) begin
      if (x > 0) lvl = sat_add(lvl, shares_up[x-1]);
      lvl = sat_add(lvl, shares_up[x]);
      if (x + 1 < w) lvl = sat_add(lvl, shares_up[x+1]);
    end
    lvl = sat_add(lvl, left2_share);
    lvl = sat_add(lvl, left_share);
    r.out_bit = (lvl > int'(LEVEL_MID));
    err = lvl - (r.out_bit ? int'(LEVEL_MAX) : 0);
    shares_up2[x] = shares_up[x];
    if (x > 0) shares_up[x-1] = left_share;
    left2_share = left_share;
    left_share = share_t'(err / SHARE_DIV);
    if (r.row_end) shares_up[x] = left_share;
    dither_q.push_back(r);
    if (r.row_end) begin
      if (rows_done < 2) rows_done++;
      start_new_row();
    end else begin
      next_col = x + 1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < 50) $display("%0t mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  // receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (rx_hold_go != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_go;
      rx_hold_left <= 80;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // result checker and receiver throttle
  always @(posedge clk) begin
    dither_result_t exp_r;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (dither_q.size() == 0) begin
          report_mismatch($sformatf("result with none pending, tdata=%h", m_axis_tdata));
        end else begin
          exp_r = dither_q.pop_front();
          if (m_axis_tdata !== {7'd0, exp_r.out_bit})
            report_mismatch($sformatf("out_bit: got tdata=%h, want %b",
                                      m_axis_tdata, exp_r.out_bit));
          if (m_axis_tlast !== exp_r.row_end)
            report_mismatch($sformatf("row_end: got %b, want %b",
                                      m_axis_tlast, exp_r.row_end));
        end
      end
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_pixel(input logic [7:0] gray, input logic frame_start);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= gray;
    s_axis_tuser  <= frame_start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_pixel(gray, frame_start);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (dither_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_reg = value;
  endtask

  function automatic logic [7:0] pick_gray();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    if (r < 25) return LEVEL_MID;
    if (r < 30) return LEVEL_MID + 8'd1;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_reset_width();
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
  endtask

  task automatic test_level_extremes();
    logic [7:0] grays[10] = '{8'd255, 8'd0, 8'd127, 8'd0, 8'd255, 8'd255,
                              8'd128, 8'd127, 8'd0, 8'd255};
    write_width(9'd3);
    foreach (grays[i]) send_pixel(grays[i], i == 0);
  endtask

  task automatic test_unit_width();
    write_width(9'd0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd0, 1'b0);
  endtask

  task automatic test_restart_and_shrink();
    write_width(9'd4);
    send_pixel(8'd200, 1'b1);
    send_pixel(8'd60, 1'b0);
    // restart mid-row, then fill one row and most of the next
    for (int i = 0; i < 7; i++) send_pixel(pick_gray(), i == 0);
    // shrink below the current column without a frame start
    write_width(9'd2);
    for (int i = 0; i < 3; i++) send_pixel(pick_gray(), 1'b0);
  endtask

  task automatic test_wide_rows();
    write_width(9'd511);
    for (int i = 0; i < MAX_W + 6; i++) send_pixel(8'($urandom_range(255)), i == 0);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_width(9'd6);
    rx_hold_go <= ~rx_hold_go;
    for (int i = 0; i < 24; i++) send_pixel(pick_gray(), i == 0);
    wait_drained();
  endtask

  task automatic test_random_frames(input int tx_pct, input int rx_pct, input int n_pixels);
    int sent;
    int r;
    int w;
    int eff;
    int count;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_pixels) begin
      r = $urandom_range(99);
      if (r < 5) w = $urandom_range(256, 511);
      else if (r < 12) w = 0;
      else if (r < 22) w = 1;
      else if (r < 85) w = $urandom_range(2, 12);
      else w = $urandom_range(13, 40);
      write_width(CFG_W'(w));
      eff = (w == 0) ? 1 : (w > MAX_W ? MAX_W : w);
      if (eff == MAX_W) count = $urandom_range(1, 20);
      else count = $urandom_range(1, 5) * eff + $urandom_range(0, eff - 1);
      if (count > n_pixels - sent) count = n_pixels - sent;
      for (int i = 0; i < count; i++) begin
        send_pixel(pick_gray(), (i == 0) || ($urandom_range(99) < 3));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_width();
    test_level_extremes();
    test_unit_width();
    test_restart_and_shrink();
    test_wide_rows();
    test_backpressure();
    test_random_frames(36, 77, 145);
    test_random_frames(77, 36, 145);
    test_random_frames(0, 0, 145);
    wait_drained();
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/atk_pkg.sv
rtl/atk_ram.sv
rtl/atk_pos.sv
rtl/atk_level.sv
rtl/atkinson_error_diffusion_1bit_unit.sv
dv/tb_atkinson_error_diffusion_1bit_unit.sv
